[rtl/core/size_ordered_download_queue_core_macros.svh]
// assertion macros for the size ordered download queue checker
// depends on nothing; expects aclk and aresetn in the scope of use
`ifndef SIZE_ORDERED_DOWNLOAD_QUEUE_CORE_MACROS_SVH
`define SIZE_ORDERED_DOWNLOAD_QUEUE_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define SODQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sodq check failed");

// next-cycle implication, held off during reset
`define SODQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sodq check failed");

`endif

[rtl/core/sodq_pkg.sv]
// types, codes and sizes shared by the download queue core
// depends on nothing
`default_nettype none
package sodq_pkg;
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = 38;

    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_CLEAR    = 4'd0;
    localparam cmd_t CMD_INSERT   = 4'd1;
    localparam cmd_t CMD_APPEND   = 4'd2;
    localparam cmd_t CMD_FIRST    = 4'd3;
    localparam cmd_t CMD_NEXT     = 4'd4;
    localparam cmd_t CMD_CONTAINS = 4'd5;
    localparam cmd_t CMD_PROMOTE  = 4'd6;
    localparam cmd_t CMD_REMOVE   = 4'd7;
    localparam cmd_t CMD_LOOKUP   = 4'd8;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] size;
        logic [31:0] id;
        logic [15:0] box;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_CUR_RD,
        S_CUR_WAIT,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

[rtl/core/sodq_ram.sv]
// simple dual port synchronous ram, one write and one registered read
// depends on nothing
`default_nettype none
module sodq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/size_ordered_download_queue_core.sv]
// top level of the size ordered download queue: sequencer around one table ram
// depends on sodq_pkg and sodq_ram
//
// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  command, server_key, message_size, message_id, mailbox
// m_       out  m_valid / m_ready  status, lookup_id, counts, current entry
//
// one beat at a time; s_ready is high only while the sequencer is idle
// a beat scans and shifts entries one at a time: each is read, then compared or written,
// as the table ram has a single read port
// reset clears count, cursor, total and the output valid; the table needs none
// a stalled result waits in the output register; the next beat is taken meanwhile
`default_nettype none
module size_ordered_download_queue_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_command,
    input  wire logic [31:0] s_server_key,
    input  wire logic [31:0] s_message_size,
    input  wire logic [31:0] s_message_id,
    input  wire logic [15:0] s_mailbox,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_lookup_id,
    output logic [6:0]       m_entry_count,
    output logic [37:0]      m_total_size,
    output logic             m_cursor_valid,
    output logic [31:0]      m_current_key,
    output logic [31:0]      m_current_size,
    output logic [31:0]      m_current_id,
    output logic [15:0]      m_current_mailbox
);
    localparam int AW = sodq_pkg::AW;
    localparam int CW = sodq_pkg::CW;
    localparam int TW = sodq_pkg::TW;

    sodq_pkg::state_t state_reg, state_next;
    sodq_pkg::cmd_t   cmd_reg, cmd_next;
    sodq_pkg::entry_t ent_reg, ent_next;      // beat payload, later the hit entry
    sodq_pkg::entry_t cur_ent_reg, cur_ent_next;
    sodq_pkg::status_t status_reg, status_next;
    logic [31:0]      lookup_reg, lookup_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    idx_reg, idx_next;      // scan index and move index
    logic [CW-1:0]    end_reg, end_next;      // move limit, also the final put address
    logic             down_reg, down_next;    // move copies from below
    logic             cvalid_reg, cvalid_next;
    logic [TW-1:0]    total_reg, total_next;
    logic             mvalid_reg, mvalid_next;
    sodq_pkg::status_t mstat_reg, mstat_next;
    logic [31:0]      mlook_reg, mlook_next;
    logic [CW-1:0]    mcount_reg, mcount_next;
    logic [TW-1:0]    mtotal_reg, mtotal_next;
    logic             mcv_reg, mcv_next;
    sodq_pkg::entry_t ment_reg, ment_next;

    // table ram port
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    sodq_pkg::entry_t         ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [sodq_pkg::EW-1:0]  ram_rdata;
    sodq_pkg::entry_t         rd;
    logic                     hit;
    logic                     more;
    logic [CW-1:0]            src;

    assign rd = sodq_pkg::entry_t'(ram_rdata);

    sodq_ram #(
        .WIDTH(sodq_pkg::EW),
        .DEPTH(sodq_pkg::DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sodq_pkg::S_IDLE;
            held_reg   <= '0;
            cur_reg    <= '0;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            cur_reg    <= cur_next;
            total_reg  <= total_next;
            mvalid_reg <= mvalid_next;
        end
        cmd_reg     <= cmd_next;
        ent_reg     <= ent_next;
        cur_ent_reg <= cur_ent_next;
        status_reg  <= status_next;
        lookup_reg  <= lookup_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        down_reg    <= down_next;
        cvalid_reg  <= cvalid_next;
        mstat_reg   <= mstat_next;
        mlook_reg   <= mlook_next;
        mcount_reg  <= mcount_next;
        mtotal_reg  <= mtotal_next;
        mcv_reg     <= mcv_next;
        ment_reg    <= ment_next;
    end

    // match test of the entry just read, by command
    always_comb begin
        case (cmd_reg)
            sodq_pkg::CMD_INSERT: hit = ent_reg.size < rd.size;
            sodq_pkg::CMD_LOOKUP: hit = rd.key == ent_reg.key;
            default:              hit = rd.id == ent_reg.id;
        endcase
    end

    // move still has entries to copy
    assign more = down_reg ? (idx_reg > end_reg) : (idx_reg < end_reg);
    assign src  = down_reg ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        ent_next     = ent_reg;
        cur_ent_next = cur_ent_reg;
        status_next  = status_reg;
        lookup_next  = lookup_reg;
        held_next    = held_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        down_next    = down_reg;
        cvalid_next  = cvalid_reg;
        total_next   = total_reg;
        mvalid_next  = mvalid_reg;
        mstat_next   = mstat_reg;
        mlook_next   = mlook_reg;
        mcount_next  = mcount_reg;
        mtotal_next  = mtotal_reg;
        mcv_next     = mcv_reg;
        ment_next    = ment_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = rd;
        ram_raddr    = '0;
        s_ready      = 1'b0;

        // result taken downstream
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            sodq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next    = s_command;
                    ent_next    = '{key: s_server_key, size: s_message_size,
                                    id: s_message_id, box: s_mailbox};
                    status_next = sodq_pkg::ST_OK;
                    lookup_next = '0;
                    state_next  = sodq_pkg::S_DISP;
                end
            end
            sodq_pkg::S_DISP: begin
                state_next = sodq_pkg::S_CUR_RD;
                case (cmd_reg)
                    sodq_pkg::CMD_CLEAR: begin
                        held_next  = '0;
                        cur_next   = '0;
                        total_next = '0;
                    end
                    sodq_pkg::CMD_INSERT, sodq_pkg::CMD_APPEND: begin
                        if (held_reg >= CW'(sodq_pkg::DEPTH)) begin
                            status_next = sodq_pkg::ST_FULL;
                        end else if (cmd_reg == sodq_pkg::CMD_INSERT) begin
                            idx_next   = '0;
                            state_next = sodq_pkg::S_SCAN_RD;
                        end else begin
                            idx_next   = held_reg;
                            end_next   = held_reg;
                            down_next  = 1'b1;
                            state_next = sodq_pkg::S_MV_RD;
                        end
                    end
                    sodq_pkg::CMD_FIRST: begin
                        if (held_reg == '0) begin
                            status_next = sodq_pkg::ST_MISS;
                        end else begin
                            cur_next = CW'(1);
                        end
                    end
                    sodq_pkg::CMD_NEXT: begin
                        if (cur_reg >= held_reg) begin
                            status_next = sodq_pkg::ST_MISS;
                        end else begin
                            cur_next = cur_reg + CW'(1);
                        end
                    end
                    sodq_pkg::CMD_CONTAINS, sodq_pkg::CMD_LOOKUP: begin
                        idx_next   = '0;
                        state_next = sodq_pkg::S_SCAN_RD;
                    end
                    sodq_pkg::CMD_PROMOTE, sodq_pkg::CMD_REMOVE: begin
                        idx_next   = cur_reg;
                        state_next = sodq_pkg::S_SCAN_RD;
                    end
                    default: begin
                        status_next = sodq_pkg::ST_MISS;
                    end
                endcase
            end
            sodq_pkg::S_SCAN_RD: begin
                if (idx_reg >= held_reg) begin
                    if (cmd_reg == sodq_pkg::CMD_INSERT) begin
                        // nothing larger: goes at the end
                        idx_next   = held_reg;
                        end_next   = held_reg;
                        down_next  = 1'b1;
                        state_next = sodq_pkg::S_MV_RD;
                    end else begin
                        status_next = sodq_pkg::ST_MISS;
                        state_next  = sodq_pkg::S_CUR_RD;
                    end
                end else begin
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = sodq_pkg::S_SCAN_CHK;
                end
            end
            sodq_pkg::S_SCAN_CHK: begin
                if (hit) begin
                    case (cmd_reg)
                        sodq_pkg::CMD_INSERT: begin
                            idx_next   = held_reg;
                            end_next   = idx_reg;
                            down_next  = 1'b1;
                            state_next = sodq_pkg::S_MV_RD;
                        end
                        sodq_pkg::CMD_PROMOTE: begin
                            ent_next   = rd;
                            end_next   = cur_reg;
                            down_next  = 1'b1;
                            state_next = sodq_pkg::S_MV_RD;
                        end
                        sodq_pkg::CMD_REMOVE: begin
                            ent_next   = rd;
                            end_next   = held_reg - CW'(1);
                            down_next  = 1'b0;
                            state_next = sodq_pkg::S_MV_RD;
                        end
                        sodq_pkg::CMD_LOOKUP: begin
                            lookup_next = rd.id;
                            state_next  = sodq_pkg::S_CUR_RD;
                        end
                        default: begin
                            state_next = sodq_pkg::S_CUR_RD;
                        end
                    endcase
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = sodq_pkg::S_SCAN_RD;
                end
            end
            sodq_pkg::S_MV_RD: begin
                if (more) begin
                    ram_raddr  = src[AW-1:0];
                    state_next = sodq_pkg::S_MV_WR;
                end else if (cmd_reg == sodq_pkg::CMD_REMOVE) begin
                    held_next  = held_reg - CW'(1);
                    total_next = total_reg - TW'(ent_reg.size);
                    state_next = sodq_pkg::S_CUR_RD;
                end else begin
                    state_next = sodq_pkg::S_PUT;
                end
            end
            sodq_pkg::S_MV_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = rd;
                idx_next   = src;
                state_next = sodq_pkg::S_MV_RD;
            end
            sodq_pkg::S_PUT: begin
                // new entry, or the promoted hit at the cursor
                ram_we    = 1'b1;
                ram_waddr = end_reg[AW-1:0];
                ram_wdata = ent_reg;
                if (cmd_reg != sodq_pkg::CMD_PROMOTE) begin
                    held_next  = held_reg + CW'(1);
                    total_next = total_reg + TW'(ent_reg.size);
                end
                state_next = sodq_pkg::S_CUR_RD;
            end
            sodq_pkg::S_CUR_RD: begin
                if (cur_reg != '0 && cur_reg <= held_reg) begin
                    ram_raddr  = AW'(cur_reg - CW'(1));
                    state_next = sodq_pkg::S_CUR_WAIT;
                end else begin
                    cvalid_next  = 1'b0;
                    cur_ent_next = '0;
                    state_next   = sodq_pkg::S_DONE;
                end
            end
            sodq_pkg::S_CUR_WAIT: begin
                cvalid_next  = 1'b1;
                cur_ent_next = rd;
                state_next   = sodq_pkg::S_DONE;
            end
            sodq_pkg::S_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    mstat_next  = status_reg;
                    mlook_next  = lookup_reg;
                    mcount_next = held_reg;
                    mtotal_next = total_reg;
                    mcv_next    = cvalid_reg;
                    ment_next   = cur_ent_reg;
                    state_next  = sodq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sodq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid           = mvalid_reg;
    assign m_status          = mstat_reg;
    assign m_lookup_id       = mlook_reg;
    assign m_entry_count     = 7'(mcount_reg);
    assign m_total_size      = mtotal_reg;
    assign m_cursor_valid    = mcv_reg;
    assign m_current_key     = ment_reg.key;
    assign m_current_size    = ment_reg.size;
    assign m_current_id      = ment_reg.id;
    assign m_current_mailbox = ment_reg.box;
endmodule
`default_nettype wire

[rtl/core/sodq_checker.sv]
// port level checks for the download queue core, bound to the top level
// depends on sodq_pkg and size_ordered_download_queue_core_macros.svh
`default_nettype none
`include "size_ordered_download_queue_core_macros.svh"
module sodq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [31:0] m_lookup_id,
    input wire logic [6:0]  m_entry_count,
    input wire logic        m_cursor_valid,
    input wire logic [31:0] m_current_key,
    input wire logic [31:0] m_current_id
);
    localparam logic [6:0] MAX_CNT = 7'(sodq_pkg::DEPTH);

    `SODQ_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_status))
    `SODQ_ASSERT_IMP(a_count, m_valid, m_entry_count <= MAX_CNT)
    `SODQ_ASSERT_IMP(a_full, m_valid && m_status == sodq_pkg::ST_FULL, m_entry_count == MAX_CNT)
    `SODQ_ASSERT_IMP(a_nocur, m_valid && !m_cursor_valid, m_current_key == '0 && m_current_id == '0)
    `SODQ_ASSERT_IMP(a_look, m_valid && m_lookup_id != '0, m_status == sodq_pkg::ST_OK)
endmodule

bind size_ordered_download_queue_core sodq_checker u_sodq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_lookup_id   (m_lookup_id),
    .m_entry_count (m_entry_count),
    .m_cursor_valid(m_cursor_valid),
    .m_current_key (m_current_key),
    .m_current_id  (m_current_id)
);
`default_nettype wire

[tb/sv/size_ordered_download_queue_core_test.sv]
// testbench for the size ordered download queue core: directed then random commands
// depends on sodq_pkg and the core; a queue model predicts every result beat
`timescale 1ns / 100ps
`default_nettype none
module size_ordered_download_queue_core_test;
    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] key;
        logic [31:0] size;
        logic [31:0] id;
        logic [15:0] box;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lookup;
        logic [6:0]  count;
        logic [37:0] total;
        logic        cur_valid;
        logic [31:0] cur_key;
        logic [31:0] cur_size;
        logic [31:0] cur_id;
        logic [15:0] cur_box;
    } queue_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0]  s_command = '0;
    logic [31:0] s_server_key = '0;
    logic [31:0] s_message_size = '0;
    logic [31:0] s_message_id = '0;
    logic [15:0] s_mailbox = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_lookup_id;
    logic [6:0]  m_entry_count;
    logic [37:0] m_total_size;
    logic        m_cursor_valid;
    logic [31:0] m_current_key;
    logic [31:0] m_current_size;
    logic [31:0] m_current_id;
    logic [15:0] m_current_mailbox;

    size_ordered_download_queue_core i_dut (.*);

    // model state: the message table, count and cursor
    sodq_pkg::entry_t msg_table [sodq_pkg::DEPTH];
    int            msg_count;
    int            msg_cursor;

    cmd_beat_t     pending_cmds[$];
    queue_report_t expected_reports[$];
    int            errors = 0;
    int            idle_cycles = 0;
    bit            stim_done = 0;
    bit            calm = 0;     // no idling in the final stretch
    bit            hold_sender = 0;

    // acceptance seen at the last rising edge
    bit s_ready_seen = 0;
    int recv_gap = 0;
    int send_gap = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // apply one command to the model and return the report it should produce
    function automatic queue_report_t apply_command(cmd_beat_t c);
        queue_report_t    r;
        sodq_pkg::entry_t e, hit;
        int               pos;
        logic [37:0]      sum;
        r = '0;
        e.key = c.key;
        e.size = c.size;
        e.id = c.id;
        e.box = c.box;
        r.status = sodq_pkg::ST_OK;
        case (c.cmd)
            sodq_pkg::CMD_CLEAR: begin
                msg_count = 0;
                msg_cursor = 0;
            end
            sodq_pkg::CMD_INSERT, sodq_pkg::CMD_APPEND: begin
                if (msg_count >= sodq_pkg::DEPTH) begin
                    r.status = sodq_pkg::ST_FULL;
                end else begin
                    pos = msg_count;
                    if (c.cmd == sodq_pkg::CMD_INSERT) begin
                        for (int i = msg_count - 1; i >= 0; i--)
                            if (e.size < msg_table[i].size) pos = i;
                    end
                    for (int i = msg_count; i > pos; i--) msg_table[i] = msg_table[i-1];
                    msg_table[pos] = e;
                    msg_count++;
                end
            end
            sodq_pkg::CMD_FIRST: begin
                if (msg_count == 0) r.status = sodq_pkg::ST_MISS;
                else msg_cursor = 1;
            end
            sodq_pkg::CMD_NEXT: begin
                if (msg_cursor >= msg_count) r.status = sodq_pkg::ST_MISS;
                else msg_cursor++;
            end
            sodq_pkg::CMD_CONTAINS: begin
                r.status = sodq_pkg::ST_MISS;
                for (int i = 0; i < msg_count; i++)
                    if (msg_table[i].id == e.id) r.status = sodq_pkg::ST_OK;
            end
            sodq_pkg::CMD_PROMOTE, sodq_pkg::CMD_REMOVE: begin
                pos = msg_count;
                for (int i = msg_count - 1; i >= msg_cursor; i--)
                    if (msg_table[i].id == e.id) pos = i;
                if (pos >= msg_count) begin
                    r.status = sodq_pkg::ST_MISS;
                end else if (c.cmd == sodq_pkg::CMD_PROMOTE) begin
                    hit = msg_table[pos];
                    for (int i = pos; i > msg_cursor; i--) msg_table[i] = msg_table[i-1];
                    msg_table[msg_cursor] = hit;
                end else begin
                    for (int i = pos; i + 1 < msg_count; i++) msg_table[i] = msg_table[i+1];
                    msg_count--;
                end
            end
            sodq_pkg::CMD_LOOKUP: begin
                r.status = sodq_pkg::ST_MISS;
                for (int i = msg_count - 1; i >= 0; i--)
                    if (msg_table[i].key == e.key) begin
                        r.status = sodq_pkg::ST_OK;
                        r.lookup = msg_table[i].id;
                    end
            end
            default: r.status = sodq_pkg::ST_MISS;
        endcase
        sum = '0;
        for (int i = 0; i < msg_count; i++) sum += 38'(msg_table[i].size);
        r.count = 7'(msg_count);
        r.total = sum;
        if (msg_cursor != 0 && msg_cursor <= msg_count) begin
            r.cur_valid = 1'b1;
            r.cur_key = msg_table[msg_cursor-1].key;
            r.cur_size = msg_table[msg_cursor-1].size;
            r.cur_id = msg_table[msg_cursor-1].id;
            r.cur_box = msg_table[msg_cursor-1].box;
        end
        return r;
    endfunction

    function automatic cmd_beat_t make_cmd(logic [3:0] cmd, logic [31:0] key,
                                           logic [31:0] size, logic [31:0] id,
                                           logic [15:0] box);
        cmd_beat_t c;
        c.cmd = cmd;
        c.key = key;
        c.size = size;
        c.id = id;
        c.box = box;
        return c;
    endfunction

    // ids and keys from a small pool so that searches hit often
    function automatic cmd_beat_t random_cmd(int pool);
        cmd_beat_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)       c.cmd = sodq_pkg::CMD_CLEAR;
        else if (pick < 22) c.cmd = sodq_pkg::CMD_INSERT;
        else if (pick < 32) c.cmd = sodq_pkg::CMD_APPEND;
        else if (pick < 40) c.cmd = sodq_pkg::CMD_FIRST;
        else if (pick < 55) c.cmd = sodq_pkg::CMD_NEXT;
        else if (pick < 63) c.cmd = sodq_pkg::CMD_CONTAINS;
        else if (pick < 73) c.cmd = sodq_pkg::CMD_PROMOTE;
        else if (pick < 85) c.cmd = sodq_pkg::CMD_REMOVE;
        else if (pick < 97) c.cmd = sodq_pkg::CMD_LOOKUP;
        else c.cmd = 4'($urandom_range(9, 15));
        c.key = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, pool));
        c.id = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, pool));
        c.size = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 40));
        c.box = 16'($urandom());
        return c;
    endfunction

    // stimulus: directed corners, a full table, then random traffic
    initial begin
        for (int i = 0; i < 6; i++) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // empty table behaviour
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_FIRST, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_PROMOTE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_REMOVE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_LOOKUP, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_CONTAINS, 0, 0, 0, 0));
        // extremes and stable ordering of equal sizes
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_INSERT, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_INSERT, 1, 5, 10, 1));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_INSERT, 2, 5, 11, 2));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_INSERT, 3, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_APPEND, 4, 1, 12, 3));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_FIRST, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_PROMOTE, 0, 0, 12, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_LOOKUP, 2, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_CONTAINS, 0, 0, '1, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_REMOVE, 0, 0, 11, 0));
        pending_cmds.push_back(make_cmd(4'd15, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(4'd9, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_CLEAR, 0, 0, 0, 0));
        // fill past capacity with the largest sizes to push the total high
        for (int i = 0; i < sodq_pkg::DEPTH + 2; i++)
            pending_cmds.push_back(make_cmd(
                ($urandom_range(0, 1) ? sodq_pkg::CMD_INSERT : sodq_pkg::CMD_APPEND),
                $urandom(), 32'hFFFF_FFFF - 32'($urandom_range(0, 3)),
                32'(i), 16'($urandom())));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_FIRST, 0, 0, 0, 0));
        for (int i = 0; i < sodq_pkg::DEPTH + 1; i++)
            pending_cmds.push_back(make_cmd(sodq_pkg::CMD_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(sodq_pkg::CMD_CLEAR, 0, 0, 0, 0));
        wait (pending_cmds.size() == 0 && expected_reports.size() == 0);
        // sender held off until every result is back
        hold_sender = 1;
        @(posedge aclk);
        hold_sender = 0;
        for (int i = 0; i < 1600; i++) begin
            if (i == 1400) calm = 1;
            pending_cmds.push_back(random_cmd((i / 200) % 2 == 0 ? 15 : 200));
            if (pending_cmds.size() > 8) wait (pending_cmds.size() <= 8);
        end
        wait (pending_cmds.size() == 0 && !s_valid);
        stim_done = 1;
    end

    // driver: presents beats at the falling edge, idles in random bursts
    always @(negedge aclk) begin
        if (!(s_valid && !s_ready_seen)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (aresetn && !hold_sender && pending_cmds.size() > 0) begin
                if (!calm && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 10);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    {s_command, s_server_key, s_message_size, s_message_id, s_mailbox}
                        <= pending_cmds.pop_front();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted command, checks each accepted result
    always @(posedge aclk) begin
        queue_report_t got, exp_r;
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_reports.push_back(apply_command(
                    {s_command, s_server_key, s_message_size, s_message_id, s_mailbox}));
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_lookup_id, m_entry_count, m_total_size, m_cursor_valid,
                       m_current_key, m_current_size, m_current_id, m_current_mailbox};
                if (expected_reports.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                    end
                    if (got.lookup !== exp_r.lookup) begin
                        $error("lookup_id exp %0h got %0h", exp_r.lookup, got.lookup); errors++;
                    end
                    if (got.count !== exp_r.count) begin
                        $error("entry_count exp %0d got %0d", exp_r.count, got.count); errors++;
                    end
                    if (got.total !== exp_r.total) begin
                        $error("total_size exp %0h got %0h", exp_r.total, got.total); errors++;
                    end
                    if (got.cur_valid !== exp_r.cur_valid) begin
                        $error("cursor_valid exp %0b got %0b", exp_r.cur_valid, got.cur_valid);
                        errors++;
                    end
                    if (got.cur_key !== exp_r.cur_key) begin
                        $error("current_key exp %0h got %0h", exp_r.cur_key, got.cur_key);
                        errors++;
                    end
                    if (got.cur_size !== exp_r.cur_size) begin
                        $error("current_size exp %0h got %0h", exp_r.cur_size, got.cur_size);
                        errors++;
                    end
                    if (got.cur_id !== exp_r.cur_id) begin
                        $error("current_id exp %0h got %0h", exp_r.cur_id, got.cur_id);
                        errors++;
                    end
                    if (got.cur_box !== exp_r.cur_box) begin
                        $error("current_mailbox exp %0h got %0h", exp_r.cur_box, got.cur_box);
                        errors++;
                    end
                end
            end
            // watchdog: cycles with no beat on either channel
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls in bursts, none in the final stretch
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            recv_gap <= $urandom_range(1, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // end of run: drain, allow the worst beat latency, then report
    initial begin
        wait (stim_done);
        wait (expected_reports.size() == 0);
        for (int i = 0; i < 4 * sodq_pkg::DEPTH + 20; i++) @(posedge aclk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= 20 * sodq_pkg::DEPTH + 200);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/sodq_pkg.sv
rtl/core/sodq_ram.sv
rtl/core/size_ordered_download_queue_core.sv
rtl/core/sodq_checker.sv
tb/sv/size_ordered_download_queue_core_test.sv
